// ===== rtl/bmprpc_pkg.sv =====
// Shared types, register codes and pixel packing for the BMP row pixel converter.
package bmprpc_pkg;

   // Default sizes
   localparam int MAX_WIDTH_DEF     = 1024;
   localparam int PALETTE_DEPTH_DEF = 256;

   // Field widths
   localparam int IMAGE_WIDTH_W = 11;
   localparam int PAL_SIZE_W    = 9;
   localparam int CSR_INDEX_W   = 3;
   localparam int CSR_DATA_W    = 11;

   // Result queue depth, holds two bursts of two pixels
   localparam int OQ_DEPTH = 4;
   localparam int OQ_LVL_W = $clog2(OQ_DEPTH + 1);

   // Register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_PIXEL_MODE    = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_IMAGE_WIDTH   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_PALETTE_SIZE  = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_OUTPUT_FORMAT = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_BLACK_TRANSP  = 3'd4;

   // Request opcodes
   localparam logic OP_PAL_WRITE = 1'b0;
   localparam logic OP_ROW_BYTE  = 1'b1;

   // Output formats
   localparam logic FMT_RGB565   = 1'b0;
   localparam logic FMT_ARGB8888 = 1'b1;

   // Row length after reset: 24 bpp, one pixel wide
   localparam int RST_DATA_LEN = 3;
   localparam int RST_ROW_PAD  = 4;

   typedef enum logic [1:0] {
      MODE_4BPP  = 2'd0,
      MODE_8BPP  = 2'd1,
      MODE_24BPP = 2'd2,
      MODE_32BPP = 2'd3
   } pixel_mode_type;

   typedef struct packed {
      logic        opcode;
      logic [7:0]  entry_index;
      logic [23:0] entry_color;
      logic [7:0]  data_byte;
   } req_type;

   typedef struct packed {
      logic [31:0] pixel_value;
      logic        last_in_row;
   } rsp_type;

   // Up to two results pushed into the output queue in one cycle
   typedef struct packed {
      logic [1:0] count;
      rsp_type    item0;
      rsp_type    item1;
   } oq_push_type;

   // Pack one R/G/B colour into the selected output word
   function automatic logic [31:0] pack_pixel(input logic [23:0] rgb,
                                              input logic        fmt,
                                              input logic        transp);
      logic [7:0]  r;
      logic [7:0]  g;
      logic [7:0]  b;
      logic [7:0]  a;
      logic [31:0] v;
      r = rgb[23:16];
      g = rgb[15:8];
      b = rgb[7:0];
      a = (transp && (rgb == 24'd0)) ? 8'd0 : 8'hFF;
      if (fmt == FMT_ARGB8888) begin
         v = {a, r, g, b};
      end else begin
         v = {16'd0, r[7:3], g[7:2], b[7:3]};
      end
      return v;
   endfunction

endpackage

// ===== rtl/bmprpc_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module bmprpc_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/bmprpc_out_queue.sv =====
// Result queue taking up to two pixels per cycle and giving one per cycle.
module bmprpc_out_queue
   import bmprpc_pkg::*;
#(
   parameter int DEPTH = OQ_DEPTH
) (
   input  logic                          clock,
   input  logic                          reset,
   input  oq_push_type                   push,
   input  logic                          pop,
   output logic [$clog2(DEPTH+1)-1:0]    level,
   output rsp_type                       head
);

   localparam int PTR_W = $clog2(DEPTH);
   localparam int LVL_W = $clog2(DEPTH + 1);

   rsp_type          slot_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] wr_ptr_in;
   logic [PTR_W-1:0] wr_ptr_nx;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_in;
   logic [LVL_W-1:0] level_ff;
   logic [LVL_W-1:0] level_in;

   // Advance pointers and level
   always_comb begin
      wr_ptr_nx = (32'(wr_ptr_ff) == DEPTH - 1) ? '0 : wr_ptr_ff + 1'b1;
      wr_ptr_in = wr_ptr_ff;
      if (push.count == 2'd1) begin
         wr_ptr_in = wr_ptr_nx;
      end else if (push.count == 2'd2) begin
         wr_ptr_in = (32'(wr_ptr_nx) == DEPTH - 1) ? '0 : wr_ptr_nx + 1'b1;
      end
      rd_ptr_in = rd_ptr_ff;
      if (pop) begin
         rd_ptr_in = (32'(rd_ptr_ff) == DEPTH - 1) ? '0 : rd_ptr_ff + 1'b1;
      end
      level_in = level_ff + LVL_W'(push.count) - LVL_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         level_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         level_ff  <= level_in;
      end
   end

   // Store pushed pixels
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         slot_ff[wr_ptr_ff] <= push.item0;
      end
      if (push.count == 2'd2) begin
         slot_ff[wr_ptr_nx] <= push.item1;
      end
   end

   assign level = level_ff;
   assign head  = slot_ff[rd_ptr_ff];

endmodule

// ===== rtl/bmp_row_pixel_converter_core.sv =====
// Top level of the BMP row pixel converter: row tracking, palette lookup, result queue.
//
//  channel | direction | handshake           | carries
//  --------+-----------+---------------------+----------------------------------
//  req     | in        | req_valid/req_stall | palette write or one row byte
//  rsp     | out       | rsp_valid/rsp_stall | one converted pixel, last flag
//  csr     | in        | csr_valid/csr_ready | register index and write data
//
// A request is taken each cycle while the result queue has room for two more
// pixels; a 4 bpp byte gives two pixels, so the single result port then sets
// the pace at one pixel per cycle while rsp is not stalled. A request's pixels
// pass the palette read and slot registers, are packed into the queue and
// leave from its head. Reset is synchronous; palette contents stay undefined until
// written. A stalled rsp holds the queue head; req_stall rises when that room runs out.
module bmp_row_pixel_converter_core
   import bmprpc_pkg::*;
#(
   parameter int MAX_WIDTH     = MAX_WIDTH_DEF,
   parameter int PALETTE_DEPTH = PALETTE_DEPTH_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   localparam int WIDTH_CAP = (1 << IMAGE_WIDTH_W) - 1;
   localparam int EFF_MAX   = (MAX_WIDTH < WIDTH_CAP) ? MAX_WIDTH : WIDTH_CAP;
   localparam int COL_W     = $clog2(EFF_MAX + 1);
   localparam int ROW_W     = $clog2(4 * EFF_MAX + 1);
   localparam int PAL_AW    = $clog2(PALETTE_DEPTH);

   typedef struct packed {
      logic        lookup;
      logic        in_range;
      logic [23:0] color;
      logic        last;
   } slot_type;

   // Configuration
   pixel_mode_type         mode_ff;
   pixel_mode_type         mode_in;
   logic [IMAGE_WIDTH_W-1:0] raw_width_in;
   logic [COL_W-1:0]       eff_width_ff;
   logic [COL_W-1:0]       eff_width_in;
   logic [ROW_W-1:0]       data_len_ff;
   logic [ROW_W-1:0]       data_len_in;
   logic [ROW_W-1:0]       row_pad_ff;
   logic [ROW_W-1:0]       row_pad_in;
   logic [PAL_SIZE_W-1:0]  pal_limit_ff;
   logic [PAL_SIZE_W-1:0]  pal_limit_in;
   logic                   out_fmt_ff;
   logic                   transp_ff;
   logic                   csr_fire;
   logic                   geom_write;
   logic [ROW_W:0]         wx;
   logic [ROW_W:0]         len_x;
   logic [ROW_W:0]         pad_x;

   // Row position
   logic [ROW_W-1:0]       row_cnt_ff;
   logic [ROW_W-1:0]       row_cnt_in;
   logic [COL_W-1:0]       col_ff;
   logic [COL_W-1:0]       col_in;
   logic [15:0]            partial_ff;
   logic [15:0]            partial_in;
   logic [1:0]             phase_ff;
   logic [1:0]             phase_in;

   // Request stage
   logic                   req_fire;
   logic                   row_fire;
   logic                   pal_wr_en;
   logic                   in_data;
   logic [ROW_W:0]         row_next;
   logic [COL_W:0]         col_p1;
   logic [COL_W:0]         col_p2;
   logic [COL_W:0]         width_x;
   logic                   emit_second;
   logic [7:0]             idx0;
   logic [7:0]             idx1;
   logic [PAL_AW-1:0]      rd_addr0;
   logic [PAL_AW-1:0]      rd_addr1;
   logic [1:0]             n_in;
   slot_type               slot0_in;
   slot_type               slot1_in;
   logic [2:0]             phase_nx;

   // Lookup stage
   logic [1:0]             s1_n_ff;
   slot_type               s1_slot0_ff;
   slot_type               s1_slot1_ff;
   logic [23:0]            rd_data0;
   logic [23:0]            rd_data1;
   logic [23:0]            color0;
   logic [23:0]            color1;
   oq_push_type            push;
   logic [OQ_LVL_W-1:0]    oq_level;
   logic                   pop;

   assign csr_ready  = 1'b1;
   assign csr_fire   = csr_valid && csr_ready;
   assign geom_write = csr_fire
                       && ((csr_index == CSR_PIXEL_MODE) || (csr_index == CSR_IMAGE_WIDTH));

   // Derive row geometry from the mode and width being written
   always_comb begin
      mode_in      = mode_ff;
      raw_width_in = IMAGE_WIDTH_W'(eff_width_ff);
      if (csr_fire && (csr_index == CSR_PIXEL_MODE)) begin
         mode_in = pixel_mode_type'(csr_data[1:0]);
      end
      if (csr_fire && (csr_index == CSR_IMAGE_WIDTH)) begin
         raw_width_in = csr_data[IMAGE_WIDTH_W-1:0];
      end
      if (raw_width_in == '0) begin
         eff_width_in = COL_W'(1);
      end else if (32'(raw_width_in) > EFF_MAX) begin
         eff_width_in = COL_W'(EFF_MAX);
      end else begin
         eff_width_in = COL_W'(raw_width_in);
      end
      wx = (ROW_W+1)'(eff_width_in);
      case (mode_in)
         MODE_4BPP: begin
            len_x = (wx + 1'b1) >> 1;
            pad_x = ((wx + (ROW_W+1)'(7)) >> 3) << 2;
         end
         MODE_8BPP: begin
            len_x = wx;
            pad_x = ((wx + (ROW_W+1)'(3)) >> 2) << 2;
         end
         MODE_24BPP: begin
            len_x = wx + (wx << 1);
            pad_x = ((len_x + (ROW_W+1)'(3)) >> 2) << 2;
         end
         default: begin
            len_x = wx << 2;
            pad_x = wx << 2;
         end
      endcase
      data_len_in  = ROW_W'(len_x);
      row_pad_in   = ROW_W'(pad_x);
      pal_limit_in = (32'(csr_data[PAL_SIZE_W-1:0]) > PALETTE_DEPTH)
                     ? PAL_SIZE_W'(PALETTE_DEPTH) : csr_data[PAL_SIZE_W-1:0];
   end

   // Hold configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff      <= MODE_24BPP;
         eff_width_ff <= COL_W'(1);
         data_len_ff  <= ROW_W'(RST_DATA_LEN);
         row_pad_ff   <= ROW_W'(RST_ROW_PAD);
         pal_limit_ff <= PAL_SIZE_W'(PALETTE_DEPTH);
         out_fmt_ff   <= FMT_RGB565;
         transp_ff    <= 1'b0;
      end else if (csr_fire) begin
         if (geom_write) begin
            mode_ff      <= mode_in;
            eff_width_ff <= eff_width_in;
            data_len_ff  <= data_len_in;
            row_pad_ff   <= row_pad_in;
         end
         if (csr_index == CSR_PALETTE_SIZE) begin
            pal_limit_ff <= pal_limit_in;
         end
         if (csr_index == CSR_OUTPUT_FORMAT) begin
            out_fmt_ff <= csr_data[0];
         end
         if (csr_index == CSR_BLACK_TRANSP) begin
            transp_ff <= csr_data[0];
         end
      end
   end

   // Stall while the queue cannot take two more pixels behind those in flight
   assign req_stall = (32'(oq_level) + 32'(s1_n_ff) + 2) > OQ_DEPTH;
   assign req_fire  = req_valid && !req_stall;
   assign row_fire  = req_fire && (req_data.opcode == OP_ROW_BYTE);
   assign pal_wr_en = req_fire && (req_data.opcode == OP_PAL_WRITE)
                      && (32'(req_data.entry_index) < PALETTE_DEPTH);

   // Decode one row byte into pixel slots and advance the row position
   always_comb begin
      in_data     = row_cnt_ff < data_len_ff;
      width_x     = (COL_W+1)'(eff_width_ff);
      col_p1      = (COL_W+1)'(col_ff) + 1'b1;
      col_p2      = (COL_W+1)'(col_ff) + (COL_W+1)'(2);
      emit_second = col_p1 < width_x;
      idx0        = req_data.data_byte;
      idx1        = {4'd0, req_data.data_byte[3:0]};
      n_in        = 2'd0;
      col_in      = col_ff;
      partial_in  = partial_ff;
      phase_in    = phase_ff;
      phase_nx    = 3'(phase_ff) + 3'd1;
      slot0_in    = '{lookup: 1'b1, in_range: 1'b0, color: 24'd0,
                      last: (col_p1 == width_x)};
      slot1_in    = '{lookup: 1'b1, in_range: 1'b0, color: 24'd0,
                      last: (col_p2 == width_x)};
      if (in_data) begin
         case (mode_ff)
            MODE_4BPP: begin
               idx0   = {4'd0, req_data.data_byte[7:4]};
               n_in   = emit_second ? 2'd2 : 2'd1;
               col_in = emit_second ? COL_W'(col_p2) : COL_W'(col_p1);
            end
            MODE_8BPP: begin
               n_in   = 2'd1;
               col_in = COL_W'(col_p1);
            end
            default: begin
               // Gather B, G, R; a fourth byte in 32 bpp is dropped
               case (phase_ff)
                  2'd0: partial_in[7:0]  = req_data.data_byte;
                  2'd1: partial_in[15:8] = req_data.data_byte;
                  2'd2: begin
                     slot0_in.lookup = 1'b0;
                     slot0_in.color  = {req_data.data_byte, partial_ff};
                     n_in            = 2'd1;
                     col_in          = COL_W'(col_p1);
                  end
                  default: ;
               endcase
               phase_in = phase_nx[1:0];
               if (phase_nx >= ((mode_ff == MODE_32BPP) ? 3'd4 : 3'd3)) begin
                  phase_in   = 2'd0;
                  partial_in = '0;
               end
            end
         endcase
      end
      slot0_in.in_range = {1'b0, idx0} < pal_limit_ff;
      slot1_in.in_range = {1'b0, idx1} < pal_limit_ff;
      rd_addr0 = slot0_in.in_range ? idx0[PAL_AW-1:0] : '0;
      rd_addr1 = slot1_in.in_range ? idx1[PAL_AW-1:0] : '0;
      // Restart at the end of the padded row
      row_next   = (ROW_W+1)'(row_cnt_ff) + 1'b1;
      row_cnt_in = ROW_W'(row_next);
      if (row_next >= (ROW_W+1)'(row_pad_ff)) begin
         row_cnt_in = '0;
         col_in     = '0;
         partial_in = '0;
         phase_in   = 2'd0;
      end
   end

   // Advance row position; a geometry write restarts the row
   always_ff @(posedge clock) begin
      if (reset || geom_write) begin
         row_cnt_ff <= '0;
         col_ff     <= '0;
         partial_ff <= '0;
         phase_ff   <= 2'd0;
      end else if (row_fire) begin
         row_cnt_ff <= row_cnt_in;
         col_ff     <= col_in;
         partial_ff <= partial_in;
         phase_ff   <= phase_in;
      end
   end

   // Palette copies: one read port per pixel of a 4 bpp byte
   bmprpc_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette_hi (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_data.entry_index[PAL_AW-1:0]),
      .wr_data (req_data.entry_color),
      .rd_en   (row_fire),
      .rd_addr (rd_addr0),
      .rd_data (rd_data0)
   );

   bmprpc_ram #(
      .WIDTH (24),
      .DEPTH (PALETTE_DEPTH)
   ) u_palette_lo (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_data.entry_index[PAL_AW-1:0]),
      .wr_data (req_data.entry_color),
      .rd_en   (row_fire),
      .rd_addr (rd_addr1),
      .rd_data (rd_data1)
   );

   // Hold pixel slots for the palette read cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_n_ff <= 2'd0;
      end else begin
         s1_n_ff <= row_fire ? n_in : 2'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (row_fire) begin
         s1_slot0_ff <= slot0_in;
         s1_slot1_ff <= slot1_in;
      end
   end

   // Resolve colours, pack and push into the queue
   always_comb begin
      color0 = s1_slot0_ff.lookup
               ? (s1_slot0_ff.in_range ? rd_data0 : 24'd0) : s1_slot0_ff.color;
      color1 = s1_slot1_ff.in_range ? rd_data1 : 24'd0;
      push.count             = s1_n_ff;
      push.item0.pixel_value = pack_pixel(color0, out_fmt_ff, transp_ff);
      push.item0.last_in_row = s1_slot0_ff.last;
      push.item1.pixel_value = pack_pixel(color1, out_fmt_ff, transp_ff);
      push.item1.last_in_row = s1_slot1_ff.last;
   end

   assign pop       = rsp_valid && !rsp_stall;
   assign rsp_valid = oq_level != '0;

   bmprpc_out_queue #(
      .DEPTH (OQ_DEPTH)
   ) u_out_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .level (oq_level),
      .head  (rsp_data)
   );

endmodule
